### rtl/mss_pkg.sv
package mss_pkg;

  localparam int CHANNELS      = 12;
  localparam int CLOCKS_PER_US = 16;
  localparam int POS_W         = 16;
  localparam int CH_W          = 4;
  localparam int SLOT_W        = $clog2(CHANNELS + 2);
  localparam int US_W          = 15;
  localparam int TIMER_W       = 16;
  localparam int CFG_W         = 15;
  localparam int CHAN_CFG_W    = 4;
  localparam int PRESCALE_SHIFT = 3;
  localparam int TRIM_US       = 3;
  localparam int IDLE_TICKS    = 4;
  localparam int DEFAULT_MIN_US = 1000;
  localparam int DEFAULT_MAX_US = 2000;
  localparam int DEFAULT_FRAME_US = 20000;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_MOVE_REL = 3'd1;
  localparam logic [2:0] OP_MOVE_ABS = 3'd2;
  localparam logic [2:0] OP_SET_POS  = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  localparam logic [1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [1:0] CFG_FRAME     = 2'd2;
  localparam logic [1:0] CFG_CHANNELS  = 2'd3;

  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;
  localparam logic signed [1:0] DIR_STOP = 2'sb00;

  typedef enum logic [2:0] {
    K_TICK,
    K_REL,
    K_ABS,
    K_SET,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [CH_W-1:0]          chan;
    logic signed [POS_W-1:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic [CHANNELS-1:0]      pin_levels;
    logic                     busy_res;
    logic                     done_flag;
    logic [CH_W-1:0]          done_channel;
    logic signed [POS_W-1:0]  position;
    logic signed [1:0]        direction;
    logic                     moving;
  } res_t;

  function automatic logic [TIMER_W-1:0] us_to_ticks(input logic signed [17:0] us);
    logic [24:0] prod;
    logic [24:0] t;
    if (us < 0) begin
      prod = '0;
    end else begin
      prod = 25'(us[16:0]) * 25'(CLOCKS_PER_US);
    end
    t = prod >> PRESCALE_SHIFT;
    if (t > 25'(16'hFFFF)) begin
      us_to_ticks = 16'hFFFF;
    end else begin
      us_to_ticks = t[TIMER_W-1:0];
    end
  endfunction

endpackage

### rtl/mss_front.sv
module mss_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            op,
  input  logic [3:0]            channel,
  input  logic signed [15:0]    amount,
  output logic                  cmd_valid,
  output mss_pkg::cmd_t         cmd,
  input  logic                  cmd_pop
);
  import mss_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       ok;
  logic       do_push;

  assign ok = channel < 4'(CHANNELS);

  always_comb begin
    cls.chan   = channel[CH_W-1:0];
    cls.amount = amount;
    case (op)
      OP_TICK:     cls.kind = K_TICK;
      OP_MOVE_REL: cls.kind = ok ? K_REL : K_NOP;
      OP_MOVE_ABS: cls.kind = ok ? K_ABS : K_NOP;
      OP_SET_POS:  cls.kind = ok ? K_SET : K_NOP;
      OP_READ:     cls.kind = ok ? K_READ : K_NOP;
      default:     cls.kind = K_NOP;
    endcase
  end

  assign full      = count == 2'd2;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(cmd_pop);
    end
  end

endmodule

### rtl/mss_out_queue.sv
module mss_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_push,
  input  mss_pkg::res_t  res_in,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output mss_pkg::res_t  res_out
);
  import mss_pkg::*;

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign res_full = count == 2'd2;
  assign empty    = count == 2'd0;
  assign res_out  = q[rd_ptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        q[wr_ptr] <= res_in;
        wr_ptr    <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(res_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/mss_back.sv
module mss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data,
  input  logic                cmd_valid,
  input  mss_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output mss_pkg::res_t       res
);
  import mss_pkg::*;

  typedef enum logic {S_RUN, S_START} state_t;

  state_t                   state, state_next;
  logic [CFG_W-1:0]         cfg_min, cfg_max, cfg_frame;
  logic [CHAN_CFG_W-1:0]    cfg_chan;

  logic [POS_W-1:0]         positions [CHANNELS];
  logic [POS_W-1:0]         targets   [CHANNELS];
  logic signed [1:0]        dirs      [CHANNELS];
  logic [TIMER_W-1:0]       pulse     [CHANNELS];
  logic [CHANNELS-1:0]      active;

  logic [SLOT_W-1:0]        slot, slot_next;
  logic [TIMER_W-1:0]       timer, timer_next;
  logic [TIMER_W-1:0]       cmp, cmp_next;
  logic [CHANNELS-1:0]      pin, pin_next;
  logic                     busy, busy_next;
  logic                     done_f, done_f_next;
  logic [CH_W-1:0]          done_ch, done_ch_next;

  logic [SLOT_W-1:0]        n;
  logic [SLOT_W-1:0]        slot_m1;
  logic [CH_W-1:0]          rd_addr;
  logic [POS_W-1:0]         r_pos, r_tgt;
  logic signed [1:0]        r_dir;
  logic [TIMER_W-1:0]       r_pulse;
  logic                     r_act;
  logic [POS_W-1:0]         pos_new;
  logic                     hit;

  logic [CFG_W-1:0]         lo, hi;
  logic signed [17:0]       lo_s, hi_s, d, d_adj, half, mid, us_sel, us_t;
  logic signed [POS_W-1:0]  steps;
  logic [POS_W-1:0]         tgt_new;
  logic signed [1:0]        dir_new;
  logic [TIMER_W-1:0]       ticks_new;
  logic [TIMER_W-1:0]       frame_ticks;
  logic [TIMER_W:0]         t4;

  logic                     wr_end, wr_move, wr_set;

  assign n       = (cfg_chan > CHAN_CFG_W'(CHANNELS)) ? SLOT_W'(CHANNELS) : SLOT_W'(cfg_chan);
  assign slot_m1 = slot - SLOT_W'(1);

  always_comb begin
    if (state == S_START || cmd.kind == K_TICK) begin
      rd_addr = (slot == '0) ? '0 : slot_m1[CH_W-1:0];
    end else begin
      rd_addr = cmd.chan;
    end
  end

  assign r_pos   = positions[rd_addr];
  assign r_tgt   = targets[rd_addr];
  assign r_dir   = dirs[rd_addr];
  assign r_pulse = pulse[rd_addr];
  assign r_act   = active[rd_addr];
  assign pos_new = r_pos + {{(POS_W-2){r_dir[1]}}, r_dir};
  assign hit     = pos_new == r_tgt;

  // pulse width selection for moves
  assign lo     = (cfg_min <= CFG_W'(1)) ? CFG_W'(DEFAULT_MIN_US) : cfg_min;
  assign hi     = (cfg_max >= cfg_frame) ? CFG_W'(DEFAULT_MAX_US) : cfg_max;
  assign lo_s   = signed'({3'b000, lo});
  assign hi_s   = signed'({3'b000, hi});
  assign d      = hi_s - lo_s;
  assign d_adj  = d + signed'(18'(d[17]));
  assign half   = d_adj >>> 1;
  assign mid    = lo_s + half;
  assign steps  = (cmd.kind == K_REL) ? cmd.amount : signed'(cmd.amount - r_pos);
  assign tgt_new = r_pos + steps;
  assign us_sel = (steps > 0) ? hi_s : ((steps < 0) ? lo_s : mid);
  assign us_t   = us_sel - signed'(18'(TRIM_US));
  assign dir_new = (steps > 0) ? DIR_FWD : ((steps < 0) ? DIR_REV : DIR_STOP);
  assign ticks_new = us_to_ticks(us_t);

  assign frame_ticks = us_to_ticks(signed'({3'b000, cfg_frame}));
  assign t4          = {1'b0, timer} + (TIMER_W+1)'(IDLE_TICKS);

  always_comb begin
    state_next   = state;
    slot_next    = slot;
    timer_next   = timer;
    cmp_next     = cmp;
    pin_next     = pin;
    busy_next    = busy;
    done_f_next  = done_f;
    done_ch_next = done_ch;
    wr_end       = 1'b0;
    wr_move      = 1'b0;
    wr_set       = 1'b0;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    case (state)
      S_RUN: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_TICK: begin
              if (timer == cmp) begin
                // slot end: retire the current channel, then open the next slot
                done_f_next  = 1'b0;
                done_ch_next = '0;
                if (slot == '0) begin
                  timer_next = '0;
                end else if (r_act) begin
                  pin_next[rd_addr] = 1'b0;
                  if (SLOT_W'(rd_addr) + SLOT_W'(1) >= n) begin
                    busy_next = 1'b0;
                  end
                  wr_end = 1'b1;
                  if (hit) begin
                    done_f_next  = 1'b1;
                    done_ch_next = rd_addr;
                  end
                end
                slot_next  = slot + SLOT_W'(1);
                state_next = S_START;
              end else begin
                timer_next = timer + TIMER_W'(1);
                res_push   = 1'b1;
              end
            end
            K_REL, K_ABS: begin
              wr_move  = 1'b1;
              res_push = 1'b1;
            end
            K_SET: begin
              wr_set   = 1'b1;
              res_push = 1'b1;
            end
            K_READ: begin
              res_push      = 1'b1;
              res.position  = signed'(r_pos);
              res.direction = r_dir;
              res.moving    = r_act;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
          res.pin_levels = pin_next;
          res.busy_res   = busy_next;
        end
      end
      S_START: begin
        if (slot_m1 < n) begin
          if (r_act) begin
            cmp_next          = timer + r_pulse;
            pin_next[rd_addr] = 1'b1;
            busy_next         = 1'b1;
          end else begin
            cmp_next = t4[TIMER_W-1:0];
          end
        end else begin
          cmp_next  = (t4 < {1'b0, frame_ticks}) ? frame_ticks : t4[TIMER_W-1:0];
          slot_next = '0;
        end
        timer_next       = timer + TIMER_W'(1);
        res_push         = 1'b1;
        res.pin_levels   = pin_next;
        res.busy_res     = busy_next;
        res.done_flag    = done_f;
        res.done_channel = done_ch;
        state_next       = S_RUN;
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      cfg_min   <= CFG_W'(DEFAULT_MIN_US);
      cfg_max   <= CFG_W'(DEFAULT_MAX_US);
      cfg_frame <= CFG_W'(DEFAULT_FRAME_US);
      cfg_chan  <= CHAN_CFG_W'(CHANNELS);
      for (int i = 0; i < CHANNELS; i++) begin
        positions[i] <= '0;
        targets[i]   <= '0;
        dirs[i]      <= DIR_STOP;
        pulse[i]     <= '0;
      end
      active  <= '0;
      slot    <= '0;
      timer   <= '0;
      cmp     <= '0;
      pin     <= '0;
      busy    <= 1'b0;
      done_f  <= 1'b0;
      done_ch <= '0;
    end else begin
      state   <= state_next;
      slot    <= slot_next;
      timer   <= timer_next;
      cmp     <= cmp_next;
      pin     <= pin_next;
      busy    <= busy_next;
      done_f  <= done_f_next;
      done_ch <= done_ch_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PULSE: cfg_min   <= cfg_data;
          CFG_MAX_PULSE: cfg_max   <= cfg_data;
          CFG_FRAME:     cfg_frame <= cfg_data;
          CFG_CHANNELS:  cfg_chan  <= cfg_data[CHAN_CFG_W-1:0];
          default: ;
        endcase
      end
      if (wr_end) begin
        positions[rd_addr] <= pos_new;
        if (hit) begin
          active[rd_addr] <= 1'b0;
        end
      end
      if (wr_move) begin
        targets[rd_addr] <= tgt_new;
        dirs[rd_addr]    <= dir_new;
        pulse[rd_addr]   <= ticks_new;
        active[rd_addr]  <= steps != 0;
      end
      if (wr_set) begin
        positions[rd_addr] <= cmd.amount;
      end
    end
  end

endmodule

### rtl/multichannel_servo_step_sequencer.sv
// Multichannel servo step sequencer.
// Input channel: drive op/channel/amount and raise push; the item is taken
// on a clock edge with push high and full low. Ops are tick, relative move,
// absolute move, set position and read.
// Result channel: one result per item, in order. While empty is low the
// oldest result sits on the result ports; pop with empty low takes it.
// Configuration: cfg_we writes cfg_data into register cfg_index (min pulse,
// max pulse, frame period, channels in use) in the same edge; write only
// while the block is idle.
// Flow: a result passes the command queue, the executor and the result
// queue. One item per cycle is sustained while the result queue is not
// full, except that a slot-ending tick holds the executor in S_RUN, then
// S_START (one state per access: channel state has a single read port).
// A two-entry queue sits on each side of the executor; when the receiver
// stops popping, the result queue fills, the executor halts, then the
// command queue fills and full rises. No item is dropped.
// Reset (rst, synchronous) restores default registers, clears all channel
// state, the frame timer, pins and both queues.
module multichannel_servo_step_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          op,
  input  logic [3:0]          channel,
  input  logic signed [15:0]  amount,
  output logic                empty,
  input  logic                pop,
  output logic [11:0]         pin_levels,
  output logic                busy_res,
  output logic                done_flag,
  output logic [3:0]          done_channel,
  output logic signed [15:0]  position,
  output logic signed [1:0]   direction,
  output logic                moving,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);
  import mss_pkg::*;

  logic  cmd_valid;
  logic  cmd_pop;
  cmd_t  cmd;
  logic  res_full;
  logic  res_push;
  res_t  res_in;
  res_t  res_out;

  mss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .channel   (channel),
    .amount    (amount),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mss_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign pin_levels   = res_out.pin_levels;
  assign busy_res     = res_out.busy_res;
  assign done_flag    = res_out.done_flag;
  assign done_channel = res_out.done_channel;
  assign position     = res_out.position;
  assign direction    = res_out.direction;
  assign moving       = res_out.moving;

endmodule
